// File: rtl/scsa_pkg.sv
// Shared types, codes and widths for the size class slot allocator.
// No dependencies; every other file imports this package.
`timescale 1ns / 1ps

package scsa_pkg;

  localparam int NUM_POOLS     = 4;
  localparam int POOL_W        = 2;
  localparam int BOUND_IDX_W   = 3;
  localparam int POOL_SHIFT    = 5;
  localparam int POOL_BYTES_SUM = 480;
  localparam int MAX_SLOTS_DEF = 256;
  localparam int MAX_REQ       = 256;

  localparam int CFG_W     = 9;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_RST   = 64;

  localparam int SIZE_W    = 16;
  localparam int OFFSET_W  = 17;
  localparam int GRANT_W   = 9;
  localparam int STATUS_W  = 3;

  localparam int QUEUE_DEPTH = 2;
  localparam int QUEUE_PTR_W = 1;
  localparam int QUEUE_CNT_W = 2;

  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE  = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK           = 3'd0,
    ST_TOO_LARGE    = 3'd1,
    ST_EXHAUSTED    = 3'd2,
    ST_BAD_SIZE     = 3'd3,
    ST_OUT_OF_RANGE = 3'd4,
    ST_MISALIGNED   = 3'd5,
    ST_STACK_FULL   = 3'd6
  } status_e;

  typedef enum logic [1:0] {
    OP_DONE = 2'd0,
    OP_POP  = 2'd1,
    OP_PUSH = 2'd2
  } op_e;

  typedef enum logic {
    B_IDLE = 1'b0,
    B_POP  = 1'b1
  } back_state_e;

  typedef struct packed {
    op_e                 op;
    logic [POOL_W-1:0]   pool;
    status_e             status;
    logic [OFFSET_W-1:0] offset;
  } req_t;

  function automatic int cap_w(int max_slots);
    return $clog2(max_slots + 1);
  endfunction

  function automatic int slot_w(int max_slots);
    return (max_slots > 1) ? $clog2(max_slots) : 1;
  endfunction

  function automatic int addr_w(int max_slots);
    int w;
    w = $clog2(max_slots * POOL_BYTES_SUM + 1);
    return (w > OFFSET_W) ? w : OFFSET_W;
  endfunction

  function automatic int cap_limit(int cfg, int max_slots);
    return (cfg > max_slots) ? max_slots : cfg;
  endfunction

  function automatic logic [GRANT_W-1:0] pool_bytes(logic [POOL_W-1:0] pool);
    return GRANT_W'(1 << POOL_SHIFT) << pool;
  endfunction

endpackage

// File: rtl/scsa_front.sv
// Front end: accepts request words, classifies them by pool and checks frees.
// Feeds a two-entry queue toward the back end. Depends on scsa_pkg.
`timescale 1ns / 1ps

module scsa_front import scsa_pkg::*; #(
  parameter int MAX_SLOTS = MAX_SLOTS_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic                       cmd_i,
  input  logic [SIZE_W-1:0]          request_size_i,
  input  logic [OFFSET_W-1:0]        handle_offset_i,
  input  logic [SIZE_W-1:0]          handle_slot_size_i,
  input  logic [addr_w(MAX_SLOTS)-1:0] bounds_i [NUM_POOLS+1],
  output logic                       q_valid_o,
  input  logic                       q_ready_i,
  output req_t                       q_data_o
);

  localparam int ADDR_W = addr_w(MAX_SLOTS);

  req_t                   cls;
  logic                   size_hit;
  logic [POOL_W-1:0]      fpool;
  logic [ADDR_W-1:0]      off_w;
  logic [ADDR_W-1:0]      lo_bound;
  logic [ADDR_W-1:0]      hi_bound;
  logic [ADDR_W-1:0]      rel;
  logic [ADDR_W-1:0]      align_mask;

  req_t                   fifo_q [QUEUE_DEPTH];
  logic [QUEUE_PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [QUEUE_PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [QUEUE_CNT_W-1:0] count_q, count_d;
  logic                   push, pop;

  always_comb begin
    size_hit = 1'b1;
    priority if (handle_slot_size_i == SIZE_W'(32)) begin
      fpool = 2'd0;
    end else if (handle_slot_size_i == SIZE_W'(64)) begin
      fpool = 2'd1;
    end else if (handle_slot_size_i == SIZE_W'(128)) begin
      fpool = 2'd2;
    end else if (handle_slot_size_i == SIZE_W'(256)) begin
      fpool = 2'd3;
    end else begin
      fpool    = 2'd0;
      size_hit = 1'b0;
    end
    off_w      = ADDR_W'(handle_offset_i);
    lo_bound   = bounds_i[BOUND_IDX_W'(fpool)];
    hi_bound   = bounds_i[BOUND_IDX_W'(fpool) + BOUND_IDX_W'(1)];
    rel        = off_w - lo_bound;
    align_mask = ADDR_W'(pool_bytes(fpool) - GRANT_W'(1));

    cls.op     = OP_DONE;
    cls.pool   = '0;
    cls.status = ST_OK;
    cls.offset = handle_offset_i;
    if (cmd_i == CMD_ALLOC) begin
      if (request_size_i > SIZE_W'(MAX_REQ)) begin
        cls.status = ST_TOO_LARGE;
      end else begin
        cls.op = OP_POP;
        priority if (request_size_i <= SIZE_W'(32)) begin
          cls.pool = 2'd0;
        end else if (request_size_i <= SIZE_W'(64)) begin
          cls.pool = 2'd1;
        end else if (request_size_i <= SIZE_W'(128)) begin
          cls.pool = 2'd2;
        end else begin
          cls.pool = 2'd3;
        end
      end
    end else begin
      cls.pool = fpool;
      priority if (!size_hit) begin
        cls.status = ST_BAD_SIZE;
      end else if (off_w < lo_bound || off_w >= hi_bound) begin
        cls.status = ST_OUT_OF_RANGE;
      end else if ((rel & align_mask) != '0) begin
        cls.status = ST_MISALIGNED;
      end else begin
        cls.op = OP_PUSH;
      end
    end
  end

  assign in_ready_o = (count_q != QUEUE_CNT_W'(QUEUE_DEPTH));
  assign q_valid_o  = (count_q != '0);
  assign q_data_o   = fifo_q[rd_ptr_q];
  assign push       = in_valid_i && in_ready_o;
  assign pop        = q_valid_o && q_ready_i;

  always_comb begin
    wr_ptr_d = push ? wr_ptr_q + QUEUE_PTR_W'(1) : wr_ptr_q;
    rd_ptr_d = pop ? rd_ptr_q + QUEUE_PTR_W'(1) : rd_ptr_q;
    count_d  = count_q + QUEUE_CNT_W'(push) - QUEUE_CNT_W'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wr_ptr_q] <= cls;
    end
  end

  a_done_fault: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (q_valid_o && q_data_o.op == OP_DONE) |-> q_data_o.status != ST_OK)
    else $error("queued fault word carries ok status");

  a_work_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (q_valid_o && (q_data_o.op == OP_POP || q_data_o.op == OP_PUSH))
      |-> q_data_o.status == ST_OK)
    else $error("queued stack word carries fault status");

endmodule

// File: rtl/scsa_back.sv
// Back end: free-offset stacks in one memory, fill counts, high-water mark
// and the result register. Depends on scsa_pkg.
`timescale 1ns / 1ps

module scsa_back import scsa_pkg::*; #(
  parameter int MAX_SLOTS = MAX_SLOTS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          rebuild_i,
  input  logic [cap_w(MAX_SLOTS)-1:0]   caps_i [NUM_POOLS],
  input  logic [addr_w(MAX_SLOTS)-1:0]  bounds_i [NUM_POOLS+1],
  input  logic                          q_valid_i,
  output logic                          q_ready_o,
  input  req_t                          q_data_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [STATUS_W-1:0]           status_o,
  output logic [OFFSET_W-1:0]           slot_offset_o,
  output logic [GRANT_W-1:0]            granted_size_o,
  output logic [OFFSET_W-1:0]           high_water_o
);

  localparam int CW     = cap_w(MAX_SLOTS);
  localparam int SW     = slot_w(MAX_SLOTS);
  localparam int ADDR_W = addr_w(MAX_SLOTS);
  localparam int MEM_AW = POOL_W + SW;
  localparam int MEM_D  = 1 << MEM_AW;
  localparam logic [CW-1:0] CAP_RST = CW'(cap_limit(CFG_RST, MAX_SLOTS));

  back_state_e         state_q, state_d;
  logic [CW-1:0]       cnt_q [NUM_POOLS];
  logic [CW-1:0]       cnt_d [NUM_POOLS];
  logic [CW-1:0]       low_q [NUM_POOLS];
  logic [CW-1:0]       low_d [NUM_POOLS];
  logic [ADDR_W-1:0]   hm_q, hm_d;

  logic                out_valid_q, out_valid_d;
  status_e             status_q, status_d;
  logic [OFFSET_W-1:0] off_q, off_d;
  logic [GRANT_W-1:0]  gsz_q, gsz_d;
  logic [OFFSET_W-1:0] hw_q, hw_d;

  logic                orig_sel_q, orig_sel_d;
  logic [ADDR_W-1:0]   orig_q, orig_d;
  logic [POOL_W-1:0]   pool_q, pool_d;

  logic [OFFSET_W-1:0] mem [MEM_D];
  logic [OFFSET_W-1:0] mem_rdata_q;
  logic                mem_we, mem_re;
  logic [MEM_AW-1:0]   mem_waddr, mem_raddr;

  logic [POOL_W-1:0]   p;
  logic [CW-1:0]       cnt_p, cap_p;
  logic [ADDR_W-1:0]   orig_val;
  logic [ADDR_W-1:0]   pop_off, pop_end;

  assign p        = q_data_i.pool;
  assign cnt_p    = cnt_q[p];
  assign cap_p    = caps_i[p];
  assign orig_val = bounds_i[BOUND_IDX_W'(p)]
                  + (ADDR_W'(cap_p - cnt_p) << (POOL_SHIFT + int'(p)));
  assign pop_off  = orig_sel_q ? orig_q : ADDR_W'(mem_rdata_q);
  assign pop_end  = pop_off + ADDR_W'(pool_bytes(pool_q));

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    low_d       = low_q;
    hm_d        = hm_q;
    out_valid_d = out_valid_q && !out_ready_i;
    status_d    = status_q;
    off_d       = off_q;
    gsz_d       = gsz_q;
    hw_d        = hw_q;
    orig_sel_d  = orig_sel_q;
    orig_d      = orig_q;
    pool_d      = pool_q;
    q_ready_o   = 1'b0;
    mem_we      = 1'b0;
    mem_re      = 1'b0;
    mem_waddr   = {p, SW'(cnt_p)};
    mem_raddr   = {p, SW'(cnt_p - CW'(1))};

    unique case (state_q)
      B_IDLE: begin
        if (q_valid_i && !rebuild_i && (!out_valid_q || out_ready_i)) begin
          q_ready_o = 1'b1;
          off_d     = '0;
          gsz_d     = '0;
          hw_d      = hm_q[OFFSET_W-1:0];
          unique case (q_data_i.op)
            OP_POP: begin
              if (cnt_p == '0) begin
                status_d    = ST_EXHAUSTED;
                out_valid_d = 1'b1;
              end else begin
                mem_re     = 1'b1;
                cnt_d[p]   = cnt_p - CW'(1);
                orig_sel_d = (cnt_p == low_q[p]);
                if (cnt_p == low_q[p]) begin
                  low_d[p] = cnt_p - CW'(1);
                end
                orig_d  = orig_val;
                pool_d  = p;
                state_d = B_POP;
              end
            end
            OP_PUSH: begin
              if (cnt_p >= cap_p) begin
                status_d = ST_STACK_FULL;
              end else begin
                status_d = ST_OK;
                mem_we   = 1'b1;
                cnt_d[p] = cnt_p + CW'(1);
              end
              out_valid_d = 1'b1;
            end
            default: begin
              status_d    = q_data_i.status;
              out_valid_d = 1'b1;
            end
          endcase
        end
      end
      B_POP: begin
        status_d    = ST_OK;
        off_d       = pop_off[OFFSET_W-1:0];
        gsz_d       = pool_bytes(pool_q);
        if (pop_end > hm_q) begin
          hm_d = pop_end;
        end
        hw_d        = hm_d[OFFSET_W-1:0];
        out_valid_d = 1'b1;
        state_d     = B_IDLE;
      end
      default: state_d = B_IDLE;
    endcase

    if (rebuild_i) begin
      cnt_d = caps_i;
      low_d = caps_i;
      hm_d  = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= B_IDLE;
      out_valid_q <= 1'b0;
      hm_q        <= '0;
      for (int i = 0; i < NUM_POOLS; i++) begin
        cnt_q[i] <= CAP_RST;
        low_q[i] <= CAP_RST;
      end
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      hm_q        <= hm_d;
      cnt_q       <= cnt_d;
      low_q       <= low_d;
    end
  end

  always_ff @(posedge clk_i) begin
    status_q   <= status_d;
    off_q      <= off_d;
    gsz_q      <= gsz_d;
    hw_q       <= hw_d;
    orig_sel_q <= orig_sel_d;
    orig_q     <= orig_d;
    pool_q     <= pool_d;
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= q_data_i.offset;
    end
    if (mem_re) begin
      mem_rdata_q <= mem[mem_raddr];
    end
  end

  assign out_valid_o    = out_valid_q;
  assign status_o       = status_q;
  assign slot_offset_o  = off_q;
  assign granted_size_o = gsz_q;
  assign high_water_o   = hw_q;

  a_pop_slot_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == B_POP) |-> !out_valid_q)
    else $error("pop completion with result register occupied");

  a_low_below_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (low_q[0] <= cnt_q[0]) && (low_q[1] <= cnt_q[1]) &&
    (low_q[2] <= cnt_q[2]) && (low_q[3] <= cnt_q[3]))
    else $error("untouched-entry mark above fill count");

  a_hm_monotonic: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !rebuild_i |=> hm_q >= $past(hm_q))
    else $error("high-water mark dropped without rebuild");

endmodule

// File: rtl/size_class_slot_allocator.sv
// A fault or free result passes the front-end queue and the result register; an
// allocation also passes the registered stack read and the back end's pop state.
// Throughput: one free or fault word per cycle while the output is not stalled;
// during an allocation's pop state the back end takes no new word.
// Reset and any pool count write leave all pools full and high water at zero;
// untouched stack entries are computed from the fill marks, no clearing pass.
`timescale 1ns / 1ps

module size_class_slot_allocator import scsa_pkg::*; #(
  parameter int MAX_SLOTS = MAX_SLOTS_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_wdata_i,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic                 cmd_i,
  input  logic [SIZE_W-1:0]    request_size_i,
  input  logic [OFFSET_W-1:0]  handle_offset_i,
  input  logic [SIZE_W-1:0]    handle_slot_size_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [STATUS_W-1:0]  status_o,
  output logic [OFFSET_W-1:0]  slot_offset_o,
  output logic [GRANT_W-1:0]   granted_size_o,
  output logic [OFFSET_W-1:0]  high_water_o
);

  localparam int CW     = cap_w(MAX_SLOTS);
  localparam int ADDR_W = addr_w(MAX_SLOTS);
  localparam logic [CW-1:0] CAP_RST = CW'(cap_limit(CFG_RST, MAX_SLOTS));

  logic [CW-1:0]     caps_q [NUM_POOLS];
  logic [CW-1:0]     caps_d [NUM_POOLS];
  logic [ADDR_W-1:0] bounds_q [NUM_POOLS+1];
  logic [ADDR_W-1:0] bounds_d [NUM_POOLS+1];
  logic              cfg_hit;
  logic              rebuild_q;

  logic              q_valid, q_ready;
  req_t              q_data;

  function automatic logic [ADDR_W-1:0] bound_rst(int idx);
    int sum;
    sum = 0;
    for (int k = 0; k < idx; k++) begin
      sum += cap_limit(CFG_RST, MAX_SLOTS) * ((1 << POOL_SHIFT) << k);
    end
    return ADDR_W'(sum);
  endfunction

  function automatic logic [CW-1:0] clamp_cap(logic [CFG_W-1:0] val);
    return (32'(val) > 32'(MAX_SLOTS)) ? CW'(MAX_SLOTS) : CW'(val);
  endfunction

  assign cfg_hit = cfg_we_i && (cfg_idx_i < CFG_IDX_W'(NUM_POOLS));

  always_comb begin
    caps_d = caps_q;
    if (cfg_hit) begin
      caps_d[cfg_idx_i[POOL_W-1:0]] = clamp_cap(cfg_wdata_i);
    end
    bounds_d[0] = '0;
    for (int i = 0; i < NUM_POOLS; i++) begin
      bounds_d[i+1] = bounds_d[i] + (ADDR_W'(caps_d[i]) << (POOL_SHIFT + i));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rebuild_q <= 1'b0;
      for (int i = 0; i < NUM_POOLS; i++) begin
        caps_q[i] <= CAP_RST;
      end
      for (int i = 0; i <= NUM_POOLS; i++) begin
        bounds_q[i] <= bound_rst(i);
      end
    end else begin
      rebuild_q <= cfg_hit;
      caps_q    <= caps_d;
      bounds_q  <= bounds_d;
    end
  end

  scsa_front #(
    .MAX_SLOTS(MAX_SLOTS)
  ) u_front (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_ready_o,
    .cmd_i,
    .request_size_i,
    .handle_offset_i,
    .handle_slot_size_i,
    .bounds_i  (bounds_q),
    .q_valid_o (q_valid),
    .q_ready_i (q_ready),
    .q_data_o  (q_data)
  );

  scsa_back #(
    .MAX_SLOTS(MAX_SLOTS)
  ) u_back (
    .clk_i,
    .rst_ni,
    .rebuild_i (rebuild_q),
    .caps_i    (caps_q),
    .bounds_i  (bounds_q),
    .q_valid_i (q_valid),
    .q_ready_o (q_ready),
    .q_data_i  (q_data),
    .out_valid_o,
    .out_ready_i,
    .status_o,
    .slot_offset_o,
    .granted_size_o,
    .high_water_o
  );

endmodule

// File: bench/tb_size_class_slot_allocator.sv
// Testbench for size_class_slot_allocator: directed corners, config extremes,
// ignored indices, random alloc/free traffic; checked by an in-bench predictor.
// Depends on scsa_pkg and the size_class_slot_allocator RTL.
`timescale 1ns / 1ps

module tb_size_class_slot_allocator;
  import scsa_pkg::*;

  localparam int REG_COUNT_SMALL  = 0;
  localparam int REG_COUNT_MEDIUM = 1;
  localparam int REG_COUNT_LARGE  = 2;
  localparam int REG_COUNT_HUGE   = 3;
  localparam int SLOT_LIMIT       = MAX_SLOTS_DEF;
  localparam int PHASES           = 14;
  localparam int PHASE_WORDS      = 103;

  typedef struct {
    status_e               status;
    logic [OFFSET_W-1:0]   offset;
    logic [GRANT_W-1:0]    size;
    logic [OFFSET_W-1:0]   high_water;
  } grant_t;

  typedef struct {
    int offset;
    int size;
  } handle_t;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  logic [CFG_W-1:0]     cfg_wdata_i;
  logic                 in_valid_i;
  logic                 in_ready_o;
  logic                 cmd_i;
  logic [SIZE_W-1:0]    request_size_i;
  logic [OFFSET_W-1:0]  handle_offset_i;
  logic [SIZE_W-1:0]    handle_slot_size_i;
  logic                 out_valid_o;
  logic                 out_ready_i;
  logic [STATUS_W-1:0]  status_o;
  logic [OFFSET_W-1:0]  slot_offset_o;
  logic [GRANT_W-1:0]   granted_size_o;
  logic [OFFSET_W-1:0]  high_water_o;

  int      pool_count [NUM_POOLS];
  int      free_stack [NUM_POOLS][SLOT_LIMIT];
  int      free_fill  [NUM_POOLS];
  int      high_mark;
  handle_t live_handles [$];
  grant_t  expected_grants [$];
  int      errors;
  bit      tx_quiet;
  bit      rx_quiet;
  int      rx_stall;

  size_class_slot_allocator u_top (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_we_i           (cfg_we_i),
    .cfg_idx_i          (cfg_idx_i),
    .cfg_wdata_i        (cfg_wdata_i),
    .in_valid_i         (in_valid_i),
    .in_ready_o         (in_ready_o),
    .cmd_i              (cmd_i),
    .request_size_i     (request_size_i),
    .handle_offset_i    (handle_offset_i),
    .handle_slot_size_i (handle_slot_size_i),
    .out_valid_o        (out_valid_o),
    .out_ready_i        (out_ready_i),
    .status_o           (status_o),
    .slot_offset_o      (slot_offset_o),
    .granted_size_o     (granted_size_o),
    .high_water_o       (high_water_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  function automatic int slot_bytes(int p);
    return 1 << (POOL_SHIFT + p);
  endfunction

  function automatic int slots_in(int p);
    return (pool_count[p] > SLOT_LIMIT) ? SLOT_LIMIT : pool_count[p];
  endfunction

  function automatic int pool_start(int p);
    int b;
    b = 0;
    for (int q = 0; q < p; q++) b += slots_in(q) * slot_bytes(q);
    return b;
  endfunction

  function automatic void reload_pools();
    int cap;
    int b;
    for (int p = 0; p < NUM_POOLS; p++) begin
      cap = slots_in(p);
      b = pool_start(p);
      for (int i = 0; i < SLOT_LIMIT; i++) free_stack[p][i] = 0;
      for (int i = 0; i < cap; i++) free_stack[p][i] = b + (cap - 1 - i) * slot_bytes(p);
      free_fill[p] = cap;
    end
    high_mark = 0;
    live_handles.delete();
  endfunction

  function automatic grant_t predict_grant(logic cmd, logic [SIZE_W-1:0] req,
                                           logic [OFFSET_W-1:0] off,
                                           logic [SIZE_W-1:0] ss);
    grant_t  g;
    handle_t h;
    int      p;
    int      sz;
    int      b;
    int      cap;
    int      o;
    bit      found;
    g.status = ST_OK;
    g.offset = '0;
    g.size = '0;
    p = 0;
    found = 1'b0;
    if (cmd == CMD_ALLOC) begin
      if (int'(req) > MAX_REQ) begin
        g.status = ST_TOO_LARGE;
      end else begin
        while (p < NUM_POOLS - 1 && int'(req) > slot_bytes(p)) p++;
        if (free_fill[p] == 0) begin
          g.status = ST_EXHAUSTED;
        end else begin
          free_fill[p]--;
          o = free_stack[p][free_fill[p]];
          if (o + slot_bytes(p) > high_mark) high_mark = o + slot_bytes(p);
          g.offset = OFFSET_W'(o);
          g.size = GRANT_W'(slot_bytes(p));
          h.offset = o;
          h.size = slot_bytes(p);
          live_handles.insert(live_handles.size(), h);
        end
      end
    end else begin
      for (int q = 0; q < NUM_POOLS; q++) begin
        if (!found && int'(ss) == slot_bytes(q)) begin
          found = 1'b1;
          p = q;
        end
      end
      if (!found) begin
        g.status = ST_BAD_SIZE;
      end else begin
        sz = slot_bytes(p);
        b = pool_start(p);
        cap = slots_in(p);
        o = int'(off);
        if (o < b || o >= b + cap * sz) g.status = ST_OUT_OF_RANGE;
        else if (((o - b) & (sz - 1)) != 0) g.status = ST_MISALIGNED;
        else if (free_fill[p] >= cap) g.status = ST_STACK_FULL;
        else begin
          free_stack[p][free_fill[p]] = o;
          free_fill[p]++;
        end
      end
    end
    g.high_water = OFFSET_W'(high_mark);
    return g;
  endfunction

  function automatic int pick_gap(bit quiet);
    int r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 40);
  endfunction

  task automatic send_word(input logic cmd, input logic [SIZE_W-1:0] req,
                           input logic [OFFSET_W-1:0] off, input logic [SIZE_W-1:0] ss);
    int gap;
    gap = pick_gap(tx_quiet);
    @(negedge clk_i);
    if (gap > 0) begin
      in_valid_i = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    cmd_i = cmd;
    request_size_i = req;
    handle_offset_i = off;
    handle_slot_size_i = ss;
    in_valid_i = 1'b1;
    do @(posedge clk_i); while (!in_ready_o);
    expected_grants.insert(expected_grants.size(), predict_grant(cmd, req, off, ss));
  endtask

  task automatic wait_idle();
    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (expected_grants.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic set_pool_count(input int idx, input int value);
    wait_idle();
    @(negedge clk_i);
    cfg_we_i = 1'b1;
    cfg_idx_i = CFG_IDX_W'(idx);
    cfg_wdata_i = CFG_W'(value);
    if (idx < NUM_POOLS) begin
      pool_count[idx] = value & ((1 << CFG_W) - 1);
      reload_pools();
    end
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  task automatic set_all_counts(input int c0, input int c1, input int c2, input int c3);
    set_pool_count(REG_COUNT_SMALL, c0);
    set_pool_count(REG_COUNT_MEDIUM, c1);
    set_pool_count(REG_COUNT_LARGE, c2);
    set_pool_count(REG_COUNT_HUGE, c3);
  endtask

  task automatic send_random_word();
    logic [SIZE_W-1:0]   req;
    logic [OFFSET_W-1:0] off;
    logic [SIZE_W-1:0]   ss;
    handle_t             h;
    int                  r;
    int                  p;
    int                  k;
    r = $urandom_range(0, 99);
    p = $urandom_range(0, NUM_POOLS - 1);
    ss = SIZE_W'(slot_bytes(p));
    off = OFFSET_W'($urandom);
    if (r >= 45 && r < 80 && live_handles.size() == 0) r = 0;
    if (r < 45) begin
      if ($urandom_range(0, 30) == 0) req = SIZE_W'($urandom_range(MAX_REQ + 1, 65535));
      else if (p == 0) req = SIZE_W'($urandom_range(0, slot_bytes(0)));
      else req = SIZE_W'($urandom_range(slot_bytes(p - 1) + 1, slot_bytes(p)));
      send_word(CMD_ALLOC, req, off, ss);
    end else if (r < 80) begin
      k = $urandom_range(0, live_handles.size() - 1);
      h = live_handles[k];
      // keep a few handles live after freeing so they get freed twice
      if (r < 75) live_handles.delete(k);
      send_word(CMD_FREE, SIZE_W'($urandom), OFFSET_W'(h.offset), SIZE_W'(h.size));
    end else if (r < 85) begin
      if (slots_in(p) > 0)
        off = OFFSET_W'(pool_start(p) + $urandom_range(0, slots_in(p) - 1) * slot_bytes(p)
                        + $urandom_range(1, slot_bytes(p) - 1));
      send_word(CMD_FREE, SIZE_W'($urandom), off, ss);
    end else if (r < 90) begin
      k = $urandom_range(0, 2);
      if (k == 0) off = OFFSET_W'(pool_start(p) + slots_in(p) * slot_bytes(p));
      else if (k == 1 && pool_start(p) > 0) off = OFFSET_W'(pool_start(p) - slot_bytes(p));
      send_word(CMD_FREE, SIZE_W'($urandom), off, ss);
    end else if (r < 95) begin
      send_word(CMD_FREE, SIZE_W'($urandom), off, SIZE_W'($urandom));
    end else begin
      send_word(1'($urandom), SIZE_W'($urandom), off, SIZE_W'($urandom));
    end
  endtask

  task automatic run_traffic(input int words);
    repeat (words) send_random_word();
  endtask

  task automatic test_directed_corners();
    int b1;
    int b2;
    int b3;
    b1 = pool_start(1);
    b2 = pool_start(2);
    b3 = pool_start(3);
    tx_quiet = 1'b0;
    rx_quiet = 1'b0;
    send_word(CMD_FREE, '0, OFFSET_W'(b3 + 5 * 256), 16'd256);
    send_word(CMD_ALLOC, 16'd0, '0, '0);
    send_word(CMD_ALLOC, 16'd32, '0, '0);
    send_word(CMD_ALLOC, 16'd33, '0, '0);
    send_word(CMD_ALLOC, 16'd64, '0, '0);
    send_word(CMD_ALLOC, 16'd65, '0, '0);
    send_word(CMD_ALLOC, 16'd128, '0, '0);
    send_word(CMD_ALLOC, 16'd129, '0, '0);
    send_word(CMD_ALLOC, 16'd256, '0, '0);
    send_word(CMD_ALLOC, 16'd257, '1, '1);
    send_word(CMD_ALLOC, 16'hFFFF, '0, '0);
    send_word(CMD_FREE, '0, '0, 16'd0);
    send_word(CMD_FREE, '1, '1, 16'hFFFF);
    send_word(CMD_FREE, '0, '0, 16'd48);
    send_word(CMD_FREE, '0, 17'h1FFFF, 16'd32);
    send_word(CMD_FREE, '0, '0, 16'd64);
    send_word(CMD_FREE, '0, OFFSET_W'(b2), 16'd64);
    send_word(CMD_FREE, '0, 17'd16, 16'd32);
    send_word(CMD_FREE, '0, OFFSET_W'(b1 + 32), 16'd64);
    send_word(CMD_FREE, '0, OFFSET_W'(b2 + 64), 16'd128);
    send_word(CMD_FREE, '0, 17'd0, 16'd32);
    send_word(CMD_FREE, '0, 17'd0, 16'd32);
    send_word(CMD_FREE, '0, 17'd0, 16'd32);
    send_word(CMD_ALLOC, 16'd1, '0, '0);
    send_word(CMD_ALLOC, 16'd1, '0, '0);
  endtask

  task automatic test_config_extremes();
    set_all_counts(0, 0, 0, 0);
    run_traffic(40);
    set_all_counts(1, 1, 1, 1);
    run_traffic(40);
    set_all_counts(511, 256, 257, 300);
    run_traffic(60);
    set_all_counts(256, 256, 256, 256);
    run_traffic(60);
    set_all_counts(3, 0, 5, 2);
    run_traffic(40);
  endtask

  task automatic test_ignored_index();
    for (int idx = NUM_POOLS; idx < (1 << CFG_IDX_W); idx++) begin
      set_pool_count(idx, $urandom_range(0, (1 << CFG_W) - 1));
      run_traffic(10);
    end
  endtask

  function automatic int pick_count();
    int r;
    r = $urandom_range(0, 9);
    if (r < 7) return $urandom_range(0, 12);
    if (r < 9) return $urandom_range(13, SLOT_LIMIT);
    return $urandom_range(SLOT_LIMIT + 1, (1 << CFG_W) - 1);
  endfunction

  task automatic test_random_traffic();
    int r;
    for (int ph = 0; ph < PHASES; ph++) begin
      r = $urandom_range(0, 3);
      if (r == 0) set_all_counts(pick_count(), pick_count(), pick_count(), pick_count());
      else if (r == 1) set_pool_count($urandom_range(0, NUM_POOLS - 1), pick_count());
      else if (r == 2) wait_idle();
      tx_quiet = ($urandom_range(0, 3) == 0);
      rx_quiet = ($urandom_range(0, 3) == 0);
      run_traffic(PHASE_WORDS);
    end
    tx_quiet = 1'b0;
    rx_quiet = 1'b0;
  endtask

  initial begin
    out_ready_i = 1'b0;
    rx_stall = 0;
    forever begin
      @(negedge clk_i);
      if (rx_stall > 0) begin
        out_ready_i = 1'b0;
        rx_stall--;
      end else begin
        out_ready_i = 1'b1;
        if (!rx_quiet && $urandom_range(0, 3) == 0) rx_stall = pick_gap(1'b0);
      end
    end
  end

  task automatic report(input string field, input int want, input int got);
    $display("%0t: %s mismatch, expected %0h actual %0h", $time, field, want, got);
    errors++;
  endtask

  always @(posedge clk_i) begin : check_results
    grant_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_grants.size() == 0) begin
        $display("%0t: unexpected word, expected none actual status %0h offset %0h",
                 $time, status_o, slot_offset_o);
        errors++;
      end else begin
        want = expected_grants.pop_front();
        if (status_o !== want.status) report("status", want.status, status_o);
        if (slot_offset_o !== want.offset) report("slot_offset", want.offset, slot_offset_o);
        if (granted_size_o !== want.size) report("granted_size", want.size, granted_size_o);
        if (high_water_o !== want.high_water)
          report("high_water", want.high_water, high_water_o);
      end
    end
  end

  initial begin
    #20_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  initial begin
    errors = 0;
    tx_quiet = 1'b0;
    rx_quiet = 1'b0;
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = '0;
    cfg_wdata_i = '0;
    in_valid_i = 1'b0;
    cmd_i = CMD_ALLOC;
    request_size_i = '0;
    handle_offset_i = '0;
    handle_slot_size_i = '0;
    for (int p = 0; p < NUM_POOLS; p++) pool_count[p] = CFG_RST;
    reload_pools();
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    test_directed_corners();
    test_config_extremes();
    test_ignored_index();
    test_random_traffic();
    wait_idle();
    repeat (8) @(posedge clk_i);
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
